### sv/firdec_pkg.sv
// ----------------------------------------------------------------------------
// firdec_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the FIR decimator.
// ----------------------------------------------------------------------------
package firdec_pkg;

    localparam int MAX_TAPS    = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;

    localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
    localparam int TAP_CFG_W   = 6;
    localparam int DEC_CFG_W   = 5;
    localparam int IDX_CFG_W   = 5;
    localparam int PHASE_W     = 4;
    localparam int DEC_MAX     = 16;

    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W       = PROD_W + TAP_IDX_W;
    localparam int FRAC_W      = COEF_BITS - 1;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TDATA_W     = 2 * SAMPLE_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPLEX_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_INDEX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_VALUE   = 3'd4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    typedef struct packed {
        logic                 shift;
        logic                 acc_clear;
        logic                 mul_en;
        logic                 acc_en;
        logic                 load_out;
        logic [TAP_IDX_W-1:0] tap;
    } dp_cmd_t;

    typedef struct packed {
        logic [TAP_IDX_W-1:0] taps_last;
        logic [DEC_CFG_W-1:0] dec_eff;
        logic                 out_free;
    } dp_stat_t;

endpackage

### sv/firdec_ctrl.sv
// ----------------------------------------------------------------------------
// firdec_ctrl
// Sequencer: takes input items, tracks the decimation phase and walks the
// shared multiply-accumulate over the active taps.
// ----------------------------------------------------------------------------
module firdec_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  firdec_pkg::dp_stat_t stat,
    output firdec_pkg::dp_cmd_t  cmd
);
    import firdec_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [TAP_IDX_W-1:0] tap_reg, tap_next;
    logic                 pend_reg;
    logic [DEC_CFG_W-1:0] phase_inc;
    logic                 accept;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign phase_inc     = DEC_CFG_W'(phase_reg) + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        tap_next      = tap_reg;
        cmd.shift     = 1'b0;
        cmd.acc_clear = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.acc_en    = pend_reg;
        cmd.load_out  = 1'b0;
        cmd.tap       = tap_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.shift  = 1'b1;
                    phase_next = (phase_inc >= stat.dec_eff) ? '0 : phase_inc[PHASE_W-1:0];
                    if (phase_reg == '0)
                    begin
                        cmd.acc_clear = 1'b1;
                        tap_next      = '0;
                        state_next    = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.mul_en = 1'b1;
                if (tap_reg == stat.taps_last)
                    state_next = ST_DRAIN;
                else
                    tap_next = tap_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            tap_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            tap_reg   <= tap_next;
            pend_reg  <= cmd.mul_en;
        end
    end

endmodule

### sv/firdec_datapath.sv
// ----------------------------------------------------------------------------
// firdec_datapath
// Configuration registers, delay lines, coefficient table, shared MAC,
// rounding/saturation and the output register.
// ----------------------------------------------------------------------------
module firdec_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [firdec_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [firdec_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [firdec_pkg::TDATA_W-1:0]        s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [firdec_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic [0:0]                            m_axis_tuser,
    input  firdec_pkg::dp_cmd_t                   cmd,
    output firdec_pkg::dp_stat_t                  stat
);
    import firdec_pkg::*;

    localparam int Q_W = ACC_W - FRAC_W + 1;
    localparam logic signed [Q_W-1:0] Q_HI = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0] Q_LO = -Q_HI - 1;

    logic [TAP_CFG_W-1:0] num_taps_reg;
    logic [DEC_CFG_W-1:0] decimation_reg;
    logic                 complex_mode_reg;
    logic [IDX_CFG_W-1:0] coef_index_reg;

    sample_t hist_re_reg [MAX_TAPS];
    sample_t hist_im_reg [MAX_TAPS];
    coef_t   coef_reg    [MAX_TAPS];

    logic signed [PROD_W-1:0] prod_re_reg, prod_im_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;

    sample_t              out_re_reg, out_im_reg;
    logic                 clip_reg;
    logic                 out_valid_reg;

    sample_t              in_re, in_im;
    logic [TAP_IDX_W-1:0] coef_addr;
    logic [SAMPLE_BITS:0] fin_re, fin_im;

    function automatic logic [SAMPLE_BITS:0] finish_fn(input logic signed [ACC_W-1:0] acc);
        logic signed [Q_W-1:0] q;
        logic                  clip;
        q = $signed({acc[ACC_W-1], acc[ACC_W-1:FRAC_W]})
            + $signed({{(Q_W-1){1'b0}}, acc[FRAC_W-1]});
        clip = 1'b0;
        if (q > Q_HI)
        begin
            q    = Q_HI;
            clip = 1'b1;
        end
        if (q < Q_LO)
        begin
            q    = Q_LO;
            clip = 1'b1;
        end
        return {clip, q[SAMPLE_BITS-1:0]};
    endfunction

    assign in_re = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_im = complex_mode_reg ? s_axis_tdata[TDATA_W-1:SAMPLE_BITS] : '0;

    always_comb
    begin
        if (num_taps_reg == '0)
            stat.taps_last = '0;
        else if (int'(num_taps_reg) >= MAX_TAPS)
            stat.taps_last = TAP_IDX_W'(MAX_TAPS - 1);
        else
            stat.taps_last = TAP_IDX_W'(num_taps_reg - 1'b1);

        if (decimation_reg == '0)
            stat.dec_eff = DEC_CFG_W'(1);
        else if (int'(decimation_reg) > DEC_MAX)
            stat.dec_eff = DEC_CFG_W'(DEC_MAX);
        else
            stat.dec_eff = decimation_reg;

        stat.out_free = !out_valid_reg || m_axis_tready;
    end

    assign coef_addr     = stat.taps_last - cmd.tap;
    assign fin_re        = finish_fn(acc_re_reg);
    assign fin_im        = finish_fn(acc_im_reg);

    // config registers and coefficient table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg     <= TAP_CFG_W'(1);
            decimation_reg   <= DEC_CFG_W'(1);
            complex_mode_reg <= 1'b0;
            coef_index_reg   <= '0;
            for (int i = 0; i < MAX_TAPS; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_NUM_TAPS:     num_taps_reg     <= cfg_wdata[TAP_CFG_W-1:0];
                REG_DECIMATION:   decimation_reg   <= cfg_wdata[DEC_CFG_W-1:0];
                REG_COMPLEX_MODE: complex_mode_reg <= cfg_wdata[0];
                REG_COEF_INDEX:   coef_index_reg   <= cfg_wdata[IDX_CFG_W-1:0];
                REG_COEF_VALUE:
                begin
                    if (int'(coef_index_reg) < MAX_TAPS)
                        coef_reg[TAP_IDX_W'(coef_index_reg)] <= cfg_wdata[COEF_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // delay lines, age 0 is the newest item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                hist_re_reg[i] <= '0;
                hist_im_reg[i] <= '0;
            end
        end
        else if (cmd.shift)
        begin
            hist_re_reg[0] <= in_re;
            hist_im_reg[0] <= in_im;
            for (int i = 1; i < MAX_TAPS; i++)
            begin
                hist_re_reg[i] <= hist_re_reg[i-1];
                hist_im_reg[i] <= hist_im_reg[i-1];
            end
        end
    end

    // MAC: product stage, then accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_re_reg <= hist_re_reg[cmd.tap] * coef_reg[coef_addr];
            prod_im_reg <= hist_im_reg[cmd.tap] * coef_reg[coef_addr];
        end
        if (cmd.acc_clear)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(prod_im_reg);
        end
        if (cmd.load_out)
        begin
            out_re_reg <= fin_re[SAMPLE_BITS-1:0];
            out_im_reg <= complex_mode_reg ? fin_im[SAMPLE_BITS-1:0] : '0;
            clip_reg   <= fin_re[SAMPLE_BITS] || (complex_mode_reg && fin_im[SAMPLE_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_im_reg, out_re_reg};
    assign m_axis_tuser  = clip_reg;

endmodule

### sv/fir_decimator_top.sv
// ----------------------------------------------------------------------------
// fir_decimator_top
// FIR decimation filter, real or complex samples, real Q1.15 coefficients.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_we                 cfg_idx, cfg_wdata
//   s_axis    in         s_axis_tvalid/tready   tdata: sample_re, sample_im
//   m_axis    out        m_axis_tvalid/tready   tdata: out_re, out_im; tuser: clipped
//
// An item that yields no result only shifts into the delay lines; an item that
// yields one starts a pass over the active taps (zero counts as one, capped
// at 32): one shared multiply-accumulate walks the taps one per cycle, then a
// drain state and a done state that rounds the sum into the output register.
// Reset clears delay lines and coefficient table at once; no clearing pass.
// A result waiting on m_axis does not block the next input item; a new sum
// waits in place, with the input stalled, until the output register frees.
// ----------------------------------------------------------------------------
module fir_decimator_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [firdec_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [firdec_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [firdec_pkg::TDATA_W-1:0]    s_axis_tdata,  // sample_re, sample_im
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [firdec_pkg::TDATA_W-1:0]    m_axis_tdata,  // out_re, out_im
    output logic [0:0]                        m_axis_tuser   // clipped
);
    import firdec_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    firdec_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    firdec_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

### sv/firdec_checker.sv
// ----------------------------------------------------------------------------
// firdec_checker
// Port-level checks for the FIR decimator, bound to the top level.
// ----------------------------------------------------------------------------
module firdec_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_we,
    input logic [firdec_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input logic [firdec_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [firdec_pkg::TDATA_W-1:0]    m_axis_tdata,
    input logic [0:0]                        m_axis_tuser
);
    import firdec_pkg::*;

    logic cplx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cplx_reg <= 1'b0;
        else if (cfg_we && cfg_idx == REG_COMPLEX_MODE)
            cplx_reg <= cfg_wdata[0];
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    a_real_im_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !cplx_reg |-> m_axis_tdata[TDATA_W-1:SAMPLE_BITS] == '0)
        else $error("imaginary output nonzero in real mode");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a busy cycle");

endmodule

bind fir_decimator_top firdec_checker u_firdec_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
